// ===== rtl/rotate_matrix_by_spin_vector_defines.svh =====
// ----------------------------------------------------------------------------
// rotate_matrix_by_spin_vector_defines
// assertion macros shared by the rotation block
// ----------------------------------------------------------------------------
`ifndef ROTATE_MATRIX_BY_SPIN_VECTOR_DEFINES_SVH
`define ROTATE_MATRIX_BY_SPIN_VECTOR_DEFINES_SVH

// condition implies effect in the same cycle
`define RMSV_ASSERT_NOW(label, clk, rst, cond, eff) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (eff)) \
      else $error("rmsv assertion failed");

// condition implies effect in the next cycle
`define RMSV_ASSERT_NEXT(label, clk, rst, cond, eff) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (eff)) \
      else $error("rmsv assertion failed");

`endif

// ===== rtl/rmsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsv_pkg
// types and constants of the spin vector rotation pipeline
// ----------------------------------------------------------------------------
package rmsv_pkg;

   localparam int VALUE_WIDTH = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      value_type in_a11;
      value_type in_a12;
      value_type in_a13;
      value_type in_a21;
      value_type in_a22;
      value_type in_a23;
      value_type in_a31;
      value_type in_a32;
      value_type in_a33;
      value_type spin_x;
      value_type spin_y;
      value_type spin_z;
   } req_type;

   typedef struct packed {
      value_type out_a11;
      value_type out_a12;
      value_type out_a13;
      value_type out_a21;
      value_type out_a22;
      value_type out_a23;
      value_type out_a31;
      value_type out_a32;
      value_type out_a33;
   } rsp_type;

   // squared norm at or below this passes the matrix through
   localparam logic [63:0] EPS_SQ      = 64'd72057;
   localparam logic [34:0] TWO_PI_Q30  = 35'h1921FB544;
   localparam logic [34:0] PI_Q30      = 35'h0C90FDAA2;
   localparam logic [34:0] HALF_PI_Q30 = 35'h06487ED51;
   localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
   localparam int          SERIES_TERMS = 10;

   // matrix a[row*3+col], vector v[0..2] = x, y, z
   typedef struct packed {
      value_type [8:0] a;
      value_type [2:0] v;
   } item_type;

   typedef struct packed {
      item_type    item;
      logic        pass;
      logic [31:0] th;
   } root_type;

   typedef struct packed {
      item_type        item;
      logic            pass;
      logic [31:0]     th;
      value_type [2:0] n;
   } norm_type;

   typedef struct packed {
      item_type        item;
      logic            pass;
      value_type [2:0] n;
      value_type       s;
      logic [31:0]     om;
   } turn_type;

endpackage

// ===== rtl/rmsv_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmsv_sqrt
// squared norm of the spin vector and its integer square root, one bit a stage
// ----------------------------------------------------------------------------
module rmsv_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rmsv_pkg::item_type  in_data,
   output logic                out_valid,
   output rmsv_pkg::root_type  out_data
);

   localparam int STEPS = 32;

   typedef struct packed {
      rmsv_pkg::item_type item;
      logic [2:0][63:0]   sq;
   } sq_type;

   typedef struct packed {
      rmsv_pkg::item_type item;
      logic               pass;
      logic [63:0]        rem;
      logic [63:0]        root;
   } step_type;

   logic             sq_valid_ff;
   sq_type           sq_ff, sq_in;
   logic [STEPS:0]   valid_ff, valid_in;
   step_type         step_ff [0:STEPS];
   step_type         step_in [0:STEPS];

   always_comb begin
      sq_in.item = in_data;
      for (int i = 0; i < 3; i++) begin
         sq_in.sq[i] = $signed(in_data.v[i]) * $signed(in_data.v[i]);
      end
   end

   always_comb begin
      step_in[0].item = sq_ff.item;
      step_in[0].rem  = sq_ff.sq[0] + sq_ff.sq[1] + sq_ff.sq[2];
      step_in[0].pass = step_in[0].rem <= rmsv_pkg::EPS_SQ;
      step_in[0].root = '0;
   end

   for (genvar i = 1; i <= STEPS; i++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (64 - 2 * i);
      logic [63:0] trial;
      always_comb begin
         trial      = step_ff[i-1].root + BIT;
         step_in[i] = step_ff[i-1];
         if (step_ff[i-1].rem >= trial) begin
            step_in[i].rem  = step_ff[i-1].rem - trial;
            step_in[i].root = (step_ff[i-1].root >> 1) + BIT;
         end else begin
            step_in[i].root = step_ff[i-1].root >> 1;
         end
      end
   end

   assign valid_in = {valid_ff[STEPS-1:0], sq_valid_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         valid_ff    <= '0;
      end else if (adv) begin
         sq_valid_ff <= in_valid;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff   <= sq_in;
         step_ff <= step_in;
      end
   end

   assign out_valid     = valid_ff[STEPS];
   assign out_data.item = step_ff[STEPS].item;
   assign out_data.pass = step_ff[STEPS].pass;
   assign out_data.th   = step_ff[STEPS].root[31:0];

endmodule

// ===== rtl/rmsv_div.sv =====
// ----------------------------------------------------------------------------
// rmsv_div
// axis components sign(v_i) * |v_i| * 2^30 / theta, three restoring dividers in lockstep
// ----------------------------------------------------------------------------
module rmsv_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rmsv_pkg::root_type  in_data,
   output logic                out_valid,
   output rmsv_pkg::norm_type  out_data
);

   localparam int QBITS = 31;

   typedef struct packed {
      rmsv_pkg::root_type base;
      logic [2:0]         neg;
      logic [2:0][33:0]   rem;
      logic [2:0][30:0]   q;
   } div_type;

   logic [QBITS-1:0] valid_ff, valid_in;
   div_type          div_ff [0:QBITS-1];
   div_type          div_in [0:QBITS-1];

   for (genvar j = 0; j < QBITS; j++) begin : g_stage
      localparam int QB = QBITS - 1 - j;
      logic [33:0] cur [0:2];
      logic [33:0] den;
      always_comb begin
         if (j == 0) begin
            div_in[j].base = in_data;
            div_in[j].q    = '0;
            for (int l = 0; l < 3; l++) begin
               div_in[j].neg[l] = in_data.item.v[l][31];
               cur[l] = in_data.item.v[l][31] ? {2'b00, ~in_data.item.v[l] + 32'd1}
                                               : {2'b00, in_data.item.v[l]};
            end
         end else begin
            div_in[j] = div_ff[j-1];
            for (int l = 0; l < 3; l++) begin
               cur[l] = {div_ff[j-1].rem[l][32:0], 1'b0};
            end
         end
         den = {2'b00, div_in[j].base.th};
         for (int l = 0; l < 3; l++) begin
            if (cur[l] >= den) begin
               div_in[j].rem[l]   = cur[l] - den;
               div_in[j].q[l][QB] = 1'b1;
            end else begin
               div_in[j].rem[l]   = cur[l];
               div_in[j].q[l][QB] = 1'b0;
            end
         end
      end
   end

   assign valid_in = {valid_ff[QBITS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff <= div_in;
      end
   end

   logic [31:0] qv [0:2];

   always_comb begin
      out_data.item = div_ff[QBITS-1].base.item;
      out_data.pass = div_ff[QBITS-1].base.pass;
      out_data.th   = div_ff[QBITS-1].base.th;
      for (int l = 0; l < 3; l++) begin
         qv[l] = {1'b0, div_ff[QBITS-1].q[l]};
         out_data.n[l] = div_ff[QBITS-1].neg[l] ? (~qv[l] + 32'd1) : qv[l];
      end
   end

   assign out_valid = valid_ff[QBITS-1];

endmodule

// ===== rtl/rmsv_trig.sv =====
// ----------------------------------------------------------------------------
// rmsv_trig
// angle reduction and sine / cosine series, three stages per series term
// ----------------------------------------------------------------------------
module rmsv_trig (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rmsv_pkg::norm_type  in_data,
   output logic                out_valid,
   output rmsv_pkg::turn_type  out_data
);

   localparam int WORK = 6 + 3 * rmsv_pkg::SERIES_TERMS;

   typedef struct packed {
      rmsv_pkg::item_type        item;
      logic                      pass;
      rmsv_pkg::value_type [2:0] n;
      logic [34:0]               t;
      logic                      sneg;
      logic                      cneg;
      logic [31:0]               x2;
      logic [31:0]               ts;
      logic [31:0]               tc;
      logic [31:0]               ps;
      logic [31:0]               pc;
      logic [63:0]               ms;
      logic [63:0]               mc;
      logic signed [33:0]        sum_s;
      logic signed [33:0]        sum_c;
   } work_type;

   logic [WORK:0]      valid_ff, valid_in;
   work_type           work_ff [0:WORK-1];
   work_type           work_in [0:WORK-1];
   rmsv_pkg::turn_type out_ff, out_in;

   logic [34:0] x4;
   logic [63:0] x2_sum;

   // angle times four moves theta to 30 fraction bits, then reduce mod 2pi
   always_comb begin
      work_in[0]      = '0;
      work_in[0].item = in_data.item;
      work_in[0].pass = in_data.pass;
      work_in[0].n    = in_data.n;
      x4 = {1'b0, in_data.th, 2'b00};
      work_in[0].t = (x4 >= rmsv_pkg::TWO_PI_Q30) ? x4 - rmsv_pkg::TWO_PI_Q30 : x4;
   end

   always_comb begin
      work_in[1] = work_ff[0];
      if (work_ff[0].t >= rmsv_pkg::TWO_PI_Q30) begin
         work_in[1].t = work_ff[0].t - rmsv_pkg::TWO_PI_Q30;
      end
   end

   always_comb begin
      work_in[2] = work_ff[1];
      if (work_ff[1].t > rmsv_pkg::PI_Q30) begin
         work_in[2].t    = rmsv_pkg::TWO_PI_Q30 - work_ff[1].t;
         work_in[2].sneg = 1'b1;
      end
   end

   always_comb begin
      work_in[3] = work_ff[2];
      if (work_ff[2].t > rmsv_pkg::HALF_PI_Q30) begin
         work_in[3].t    = rmsv_pkg::PI_Q30 - work_ff[2].t;
         work_in[3].cneg = 1'b1;
      end
   end

   always_comb begin
      work_in[4]    = work_ff[3];
      work_in[4].ms = work_ff[3].t[31:0] * work_ff[3].t[31:0];
   end

   always_comb begin
      work_in[5]       = work_ff[4];
      x2_sum           = work_ff[4].ms + 64'd536870912;
      work_in[5].x2    = x2_sum[61:30];
      work_in[5].ts    = work_ff[4].t[31:0];
      work_in[5].tc    = rmsv_pkg::ONE_Q30;
      work_in[5].sum_s = $signed({3'b000, work_ff[4].t[30:0]});
      work_in[5].sum_c = $signed({2'b00, rmsv_pkg::ONE_Q30});
   end

   for (genvar k = 1; k <= rmsv_pkg::SERIES_TERMS; k++) begin : g_term
      localparam int          B   = 6 + 3 * (k - 1);
      localparam logic [40:0] DS  = 41'((2 * k) * (2 * k + 1));
      localparam logic [40:0] DC  = 41'((2 * k - 1) * (2 * k));
      localparam logic [31:0] MS  = 32'((64'd1 << 32) / DS);
      localparam logic [31:0] MC  = 32'((64'd1 << 32) / DC);
      localparam bit          SUB = (k % 2) == 1;

      logic [63:0] prod_s, prod_c;
      logic [31:0] q0_s, q0_c, q_s, q_c;
      logic [40:0] qd_s, qd_c, r_s, r_c;

      always_comb begin
         work_in[B]    = work_ff[B-1];
         prod_s        = work_ff[B-1].ts * work_ff[B-1].x2;
         prod_c        = work_ff[B-1].tc * work_ff[B-1].x2;
         work_in[B].ps = prod_s[61:30];
         work_in[B].pc = prod_c[61:30];
      end

      // division by the term's constant through its reciprocal
      always_comb begin
         work_in[B+1]    = work_ff[B];
         work_in[B+1].ms = work_ff[B].ps * MS;
         work_in[B+1].mc = work_ff[B].pc * MC;
      end

      // the reciprocal quotient is low by at most one
      always_comb begin
         work_in[B+2] = work_ff[B+1];
         q0_s = work_ff[B+1].ms[63:32];
         q0_c = work_ff[B+1].mc[63:32];
         qd_s = q0_s * DS;
         qd_c = q0_c * DC;
         r_s  = {9'd0, work_ff[B+1].ps} - qd_s;
         r_c  = {9'd0, work_ff[B+1].pc} - qd_c;
         q_s  = q0_s + {31'd0, r_s >= DS};
         q_c  = q0_c + {31'd0, r_c >= DC};
         work_in[B+2].ts = q_s;
         work_in[B+2].tc = q_c;
         if (SUB) begin
            work_in[B+2].sum_s = work_ff[B+1].sum_s - $signed({2'b00, q_s});
            work_in[B+2].sum_c = work_ff[B+1].sum_c - $signed({2'b00, q_c});
         end else begin
            work_in[B+2].sum_s = work_ff[B+1].sum_s + $signed({2'b00, q_s});
            work_in[B+2].sum_c = work_ff[B+1].sum_c + $signed({2'b00, q_c});
         end
      end
   end

   logic signed [33:0] one_s, s_cl, c_cl;
   logic [31:0]        s_mag;

   always_comb begin
      one_s = $signed({2'b00, rmsv_pkg::ONE_Q30});
      if (work_ff[WORK-1].sum_s < 0) begin
         s_cl = '0;
      end else if (work_ff[WORK-1].sum_s > one_s) begin
         s_cl = one_s;
      end else begin
         s_cl = work_ff[WORK-1].sum_s;
      end
      if (work_ff[WORK-1].sum_c < 0) begin
         c_cl = '0;
      end else if (work_ff[WORK-1].sum_c > one_s) begin
         c_cl = one_s;
      end else begin
         c_cl = work_ff[WORK-1].sum_c;
      end
      s_mag       = s_cl[31:0];
      out_in.item = work_ff[WORK-1].item;
      out_in.pass = work_ff[WORK-1].pass;
      out_in.n    = work_ff[WORK-1].n;
      out_in.s    = work_ff[WORK-1].sneg ? (~s_mag + 32'd1) : s_mag;
      out_in.om   = work_ff[WORK-1].cneg ? rmsv_pkg::ONE_Q30 + c_cl[31:0]
                                         : rmsv_pkg::ONE_Q30 - c_cl[31:0];
   end

   assign valid_in = {valid_ff[WORK-1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         work_ff <= work_in;
         out_ff  <= out_in;
      end
   end

   assign out_valid = valid_ff[WORK];
   assign out_data  = out_ff;

endmodule

// ===== rtl/rmsv_rot.sv =====
// ----------------------------------------------------------------------------
// rmsv_rot
// builds the rotation from axis, sine and one minus cosine, applies it to the
// orientation matrix and saturates; the last stage is the output register
// ----------------------------------------------------------------------------
module rmsv_rot (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rmsv_pkg::turn_type  in_data,
   output logic                out_valid,
   output rmsv_pkg::rsp_type   out_data
);

   typedef struct packed {
      rmsv_pkg::item_type item;
      logic               pass;
   } head_type;

   typedef struct packed {
      head_type         head;
      logic [31:0]      om;
      logic [2:0][63:0] sq;
      logic [2:0][63:0] cr;
      logic [2:0][63:0] sn;
   } r0_type;

   typedef struct packed {
      head_type         head;
      logic [31:0]      om;
      logic [33:0]      nn;
      logic [2:0][33:0] rsq;
      logic [2:0][33:0] rcr;
      logic [2:0][33:0] sp;
      logic [2:0][33:0] sm;
   } r1_type;

   typedef struct packed {
      head_type         head;
      logic [31:0]      om;
      logic [8:0][33:0] k2;
      logic [8:0][33:0] sk;
   } r2_type;

   typedef struct packed {
      head_type         head;
      logic [8:0][67:0] ok2;
      logic [8:0][33:0] sk;
   } r3_type;

   typedef struct packed {
      head_type         head;
      logic [8:0][35:0] r;
   } r4_type;

   typedef struct packed {
      head_type          head;
      logic [26:0][67:0] pr;
   } r5_type;

   function automatic logic signed [67:0] round30(input logic signed [67:0] p);
      logic signed [67:0] q;
      q = p + 68'sd536870912;
      return q >>> 30;
   endfunction

   logic [6:0]        valid_ff, valid_in;
   r0_type            r0_ff, r0_in;
   r1_type            r1_ff, r1_in;
   r2_type            r2_ff, r2_in;
   r3_type            r3_ff, r3_in;
   r4_type            r4_ff, r4_in;
   r5_type            r5_ff, r5_in;
   rmsv_pkg::rsp_type out_ff, out_in;

   always_comb begin
      r0_in.head.item = in_data.item;
      r0_in.head.pass = in_data.pass;
      r0_in.om        = in_data.om;
      for (int i = 0; i < 3; i++) begin
         r0_in.sq[i] = $signed(in_data.n[i]) * $signed(in_data.n[i]);
         r0_in.sn[i] = $signed(in_data.s) * $signed(in_data.n[i]);
      end
      r0_in.cr[0] = $signed(in_data.n[0]) * $signed(in_data.n[1]);
      r0_in.cr[1] = $signed(in_data.n[0]) * $signed(in_data.n[2]);
      r0_in.cr[2] = $signed(in_data.n[1]) * $signed(in_data.n[2]);
   end

   logic signed [67:0] nn_w, t1;

   always_comb begin
      r1_in.head = r0_ff.head;
      r1_in.om   = r0_ff.om;
      nn_w = round30($signed(r0_ff.sq[0]) + $signed(r0_ff.sq[1]) + $signed(r0_ff.sq[2]));
      r1_in.nn = nn_w[33:0];
      for (int i = 0; i < 3; i++) begin
         t1 = round30($signed(r0_ff.sq[i]));
         r1_in.rsq[i] = t1[33:0];
         t1 = round30($signed(r0_ff.cr[i]));
         r1_in.rcr[i] = t1[33:0];
         t1 = round30($signed(r0_ff.sn[i]));
         r1_in.sp[i] = t1[33:0];
         // the skew entry carries its own sign, so round the negated product
         t1 = round30(68'sd0 - $signed(r0_ff.sn[i]));
         r1_in.sm[i] = t1[33:0];
      end
   end

   always_comb begin
      r2_in.head  = r1_ff.head;
      r2_in.om    = r1_ff.om;
      r2_in.k2[0] = r1_ff.rsq[0] - r1_ff.nn;
      r2_in.k2[1] = r1_ff.rcr[0];
      r2_in.k2[2] = r1_ff.rcr[1];
      r2_in.k2[3] = r1_ff.rcr[0];
      r2_in.k2[4] = r1_ff.rsq[1] - r1_ff.nn;
      r2_in.k2[5] = r1_ff.rcr[2];
      r2_in.k2[6] = r1_ff.rcr[1];
      r2_in.k2[7] = r1_ff.rcr[2];
      r2_in.k2[8] = r1_ff.rsq[2] - r1_ff.nn;
      r2_in.sk[0] = '0;
      r2_in.sk[1] = r1_ff.sm[2];
      r2_in.sk[2] = r1_ff.sp[1];
      r2_in.sk[3] = r1_ff.sp[2];
      r2_in.sk[4] = '0;
      r2_in.sk[5] = r1_ff.sm[0];
      r2_in.sk[6] = r1_ff.sm[1];
      r2_in.sk[7] = r1_ff.sp[0];
      r2_in.sk[8] = '0;
   end

   always_comb begin
      r3_in.head = r2_ff.head;
      r3_in.sk   = r2_ff.sk;
      for (int e = 0; e < 9; e++) begin
         r3_in.ok2[e] = $signed({1'b0, r2_ff.om}) * $signed(r2_ff.k2[e]);
      end
   end

   logic signed [67:0] r_w;

   always_comb begin
      r4_in.head = r3_ff.head;
      for (int e = 0; e < 9; e++) begin
         r_w = $signed(r3_ff.sk[e]) + round30($signed(r3_ff.ok2[e]));
         if (e == 0 || e == 4 || e == 8) begin
            r_w = r_w + 68'sd1073741824;
         end
         r4_in.r[e] = r_w[35:0];
      end
   end

   always_comb begin
      r5_in.head = r4_ff.head;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               r5_in.pr[(i * 3 + j) * 3 + k] =
                  $signed(r4_ff.r[i * 3 + k]) * $signed(r4_ff.head.item.a[k * 3 + j]);
            end
         end
      end
   end

   logic signed [67:0] acc [0:8];
   logic [31:0]        res [0:8];

   always_comb begin
      for (int e = 0; e < 9; e++) begin
         acc[e] = round30($signed(r5_ff.pr[e * 3])) + round30($signed(r5_ff.pr[e * 3 + 1]))
                + round30($signed(r5_ff.pr[e * 3 + 2]));
         if (r5_ff.head.pass) begin
            res[e] = r5_ff.head.item.a[e];
         end else if (acc[e] > 68'sd2147483647) begin
            res[e] = 32'h7FFF_FFFF;
         end else if (acc[e] < -68'sd2147483648) begin
            res[e] = 32'h8000_0000;
         end else begin
            res[e] = acc[e][31:0];
         end
      end
      out_in.out_a11 = res[0];
      out_in.out_a12 = res[1];
      out_in.out_a13 = res[2];
      out_in.out_a21 = res[3];
      out_in.out_a22 = res[4];
      out_in.out_a23 = res[5];
      out_in.out_a31 = res[6];
      out_in.out_a32 = res[7];
      out_in.out_a33 = res[8];
   end

   assign valid_in = {valid_ff[5:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r0_ff  <= r0_in;
         r1_ff  <= r1_in;
         r2_ff  <= r2_in;
         r3_ff  <= r3_in;
         r4_ff  <= r4_in;
         r5_ff  <= r5_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff[6];
   assign out_data  = out_ff;

endmodule

// ===== rtl/rotate_matrix_by_spin_vector.sv =====
// ----------------------------------------------------------------------------
// rotate_matrix_by_spin_vector
// rotates a 3x3 Q4.28 orientation matrix by a spin vector
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted every clock while no result is held
// at the output; there are 2 norm stages, 32 square root stages, 31 divider stages,
// 37 reduction and series stages and 7 rotation stages including the output
// register. The depth is set by the bit-per-stage square root and axis
// dividers and by the three stages of each of the ten series terms. A stalled
// result freezes the whole pipeline, so req_stall follows rsp_stall while a
// result is waiting; otherwise no cycle is lost. Vectors with a norm of at
// most 1e-6 return the matrix unchanged; all other results saturate to the
// 32-bit range.
`include "rotate_matrix_by_spin_vector_defines.svh"

module rotate_matrix_by_spin_vector (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rmsv_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmsv_pkg::rsp_type rsp_data
);

   logic               adv;
   rmsv_pkg::item_type req_item;
   logic               root_valid, norm_valid, turn_valid;
   rmsv_pkg::root_type root_data;
   rmsv_pkg::norm_type norm_data;
   rmsv_pkg::turn_type turn_data;

   // the pipeline moves unless a finished item is held at the output
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      req_item.a[0] = req_data.in_a11;
      req_item.a[1] = req_data.in_a12;
      req_item.a[2] = req_data.in_a13;
      req_item.a[3] = req_data.in_a21;
      req_item.a[4] = req_data.in_a22;
      req_item.a[5] = req_data.in_a23;
      req_item.a[6] = req_data.in_a31;
      req_item.a[7] = req_data.in_a32;
      req_item.a[8] = req_data.in_a33;
      req_item.v[0] = req_data.spin_x;
      req_item.v[1] = req_data.spin_y;
      req_item.v[2] = req_data.spin_z;
   end

   rmsv_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_item),
      .out_valid (root_valid),
      .out_data  (root_data)
   );

   rmsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (root_valid),
      .in_data   (root_data),
      .out_valid (norm_valid),
      .out_data  (norm_data)
   );

   rmsv_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (norm_valid),
      .in_data   (norm_data),
      .out_valid (turn_valid),
      .out_data  (turn_data)
   );

   rmsv_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (turn_valid),
      .in_data   (turn_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   `RMSV_ASSERT_NOW(a_stall_from_output, clock, reset, req_stall, rsp_valid && rsp_stall)
   `RMSV_ASSERT_NOW(a_result_needs_advance, clock, reset, $rose(rsp_valid), $past(adv))
   `RMSV_ASSERT_NEXT(a_pipe_holds, clock, reset, !adv, $stable(turn_data) && $stable(root_data))

endmodule

// ===== verif/rotation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_checker
// watches both channels of the spin vector rotation block, computes the
// rotated matrix of every accepted item and compares it with the result
// ----------------------------------------------------------------------------
module rotation_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  rmsv_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rmsv_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                pending_count
);

   localparam longint unsigned PI_FIX = 64'hC90FDAA2;
   localparam longint          UNIT   = 64'sd1 << 30;

   rmsv_pkg::rsp_type rotated_queue[$];

   function automatic longint rnd30(longint p);
      return (p + (64'sd1 << 29)) >>> 30;
   endfunction

   function automatic rmsv_pkg::rsp_type rotate_item(rmsv_pkg::req_type r);
      logic [383:0]      raw;
      logic [287:0]      flat;
      longint            a[3][3];
      longint            v[3];
      longint            nv[3];
      longint            kk[3][3];
      longint            k2;
      longint            rm[3][3];
      longint unsigned   sq, th, t, rem, bitv, x2, ts, tc, mag;
      longint            sn, cs, om, nn, acc;
      bit                sneg, cneg;
      raw = r;
      sq = 0;
      for (int i = 0; i < 9; i++)
         a[i/3][i%3] = longint'($signed(raw[(11-i)*32 +: 32]));
      for (int i = 0; i < 3; i++) begin
         v[i] = longint'($signed(raw[(2-i)*32 +: 32]));
         sq += longint'(v[i] * v[i]);
      end
      // tiny vector: matrix goes straight through
      if (sq <= 64'd72057) begin
         return rmsv_pkg::rsp_type'(raw[383:96]);
      end
      // bitwise integer square root
      rem = sq;
      th = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= th + bitv) begin
            rem -= th + bitv;
            th = (th >> 1) + bitv;
         end else begin
            th >>= 1;
         end
         bitv >>= 2;
      end
      t = (th << 2) % (2 * PI_FIX);
      sneg = 0;
      cneg = 0;
      if (t > PI_FIX) begin
         t = 2 * PI_FIX - t;
         sneg = 1;
      end
      if (t > PI_FIX / 2) begin
         t = PI_FIX - t;
         cneg = 1;
      end
      x2 = (t * t + (64'd1 << 29)) >> 30;
      ts = t;
      tc = 64'd1 << 30;
      sn = longint'(t);
      cs = UNIT;
      for (longint unsigned k = 1; k <= 10; k++) begin
         ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
         tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
         if (k[0]) begin
            sn -= longint'(ts);
            cs -= longint'(tc);
         end else begin
            sn += longint'(ts);
            cs += longint'(tc);
         end
      end
      sn = sn < 0 ? 0 : (sn > UNIT ? UNIT : sn);
      cs = cs < 0 ? 0 : (cs > UNIT ? UNIT : cs);
      if (sneg) sn = -sn;
      om = cneg ? UNIT + cs : UNIT - cs;
      for (int i = 0; i < 3; i++) begin
         mag = v[i] < 0 ? -v[i] : v[i];
         nv[i] = longint'((mag << 30) / th);
         if (v[i] < 0) nv[i] = -nv[i];
      end
      kk[0][0] = 0;      kk[0][1] = -nv[2]; kk[0][2] = nv[1];
      kk[1][0] = nv[2];  kk[1][1] = 0;      kk[1][2] = -nv[0];
      kk[2][0] = -nv[1]; kk[2][1] = nv[0];  kk[2][2] = 0;
      nn = rnd30(nv[0] * nv[0] + nv[1] * nv[1] + nv[2] * nv[2]);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            k2 = rnd30(nv[i] * nv[j]) - (i == j ? nn : 0);
            rm[i][j] = (i == j ? UNIT : 0) + rnd30(sn * kk[i][j]) + rnd30(om * k2);
         end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += rnd30(rm[i][k] * a[k][j]);
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            flat[(8-(i*3+j))*32 +: 32] = acc[31:0];
         end
      return rmsv_pkg::rsp_type'(flat);
   endfunction

   always @(posedge clock) begin
      logic [287:0] want, got;
      string        names[9];
      if (reset) begin
         rotated_queue.delete();
         error_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            rotated_queue.push_back(rotate_item(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (rotated_queue.size() == 0) begin
               $error("result item with nothing expected");
               error_count <= error_count + 1;
            end else begin
               names = '{"out_a11", "out_a12", "out_a13", "out_a21", "out_a22",
                         "out_a23", "out_a31", "out_a32", "out_a33"};
               want = rotated_queue.pop_front();
               got = rsp_data;
               if (want != got) error_count <= error_count + 1;
               for (int f = 0; f < 9; f++)
                  if (want[(8-f)*32 +: 32] != got[(8-f)*32 +: 32])
                     $error("%s: expected %0d, got %0d", names[f],
                            $signed(want[(8-f)*32 +: 32]), $signed(got[(8-f)*32 +: 32]));
            end
         end
      end
      pending_count <= rotated_queue.size();
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the spin vector rotation block: directed corner
// items, then random items under several idle and stall patterns
// ----------------------------------------------------------------------------
module tb_top;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   rmsv_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rmsv_pkg::rsp_type rsp_data;
   int                error_count;
   int                pending_count;
   int                idle_pct;
   int                stall_pct;
   bit                hold_off;

   rotate_matrix_by_spin_vector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rotation_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver side
   initial begin
      rsp_stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // each idle cycle is drawn separately so idle_pct is the share of idle cycles
   task automatic send_item(rmsv_pkg::req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [31:0] pick_entry();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 * 268435456)) - 268435456);
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(65535)) - 32768);
      endcase
   endfunction

   function automatic logic [31:0] pick_spin();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(310)) - 155);
         2: return 32'($signed($urandom_range(6000)) - 3000);
         default: return 32'($signed($urandom_range(32'd3373259426)) - 1686629713);
      endcase
   endfunction

   function automatic rmsv_pkg::req_type make_item(logic [31:0] fill, logic [31:0] sx,
                                                   logic [31:0] sy, logic [31:0] sz);
      rmsv_pkg::req_type r;
      r = '{default: fill};
      r.in_a11 = 32'sh1000_0000;
      r.in_a22 = 32'sh1000_0000;
      r.in_a33 = 32'sh1000_0000;
      r.spin_x = sx;
      r.spin_y = sy;
      r.spin_z = sz;
      return r;
   endfunction

   initial begin
      rmsv_pkg::req_type item;
      logic [383:0] raw;
      int pcts[4][2];
      reset     = 1;
      req_valid = 0;
      req_data  = '0;
      idle_pct  = 0;
      stall_pct = 0;
      hold_off  = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: tiny vectors, angle multiples of pi, field extremes
      send_item(make_item(32'h0, 32'h0, 32'h0, 32'h0));
      send_item(make_item(32'h0, 32'd268, 32'h0, 32'h0));
      send_item(make_item(32'h0, 32'd269, 32'h0, 32'h0));
      send_item(make_item(32'h0, 32'd155, -32'sd155, 32'd155));
      send_item(make_item(32'h123, 32'd843314856, 32'h0, 32'h0));
      send_item(make_item(32'h0, 32'h0, -32'sd843314856, 32'h0));
      send_item(make_item(32'h0, 32'h0, 32'h0, 32'd1686629713));
      send_item(make_item(32'h0, 32'd421657428, 32'h0, 32'h0));
      send_item(make_item(32'h0, 32'd2147483647, 32'd2147483647, 32'd2147483647));
      send_item(make_item(32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_item(make_item(32'h7FFF_FFFF, 32'd200000000, 32'h0, 32'h0));
      send_item(make_item(32'h8000_0000, 32'h0, 32'd200000000, 32'h0));
      item = '{default: 32'h7FFF_FFFF};
      send_item(item);
      item.spin_z = 32'd300000000;
      send_item(item);
      item = '{default: 32'h8000_0000};
      send_item(item);
      item.spin_x = 32'd2000000;
      send_item(item);
      item = '{default: 32'h5555_5555};
      send_item(item);
      item = '{default: 32'hAAAA_AAAA};
      send_item(item);

      pcts = '{'{0, 0}, '{86, 0}, '{0, 86}, '{22, 22}};
      for (int p = 0; p < 4; p++) begin
         idle_pct  = pcts[p][0];
         stall_pct = pcts[p][1];
         if (p == 0) hold_off = 1;
         for (int n = 0; n < 235; n++) begin
            for (int f = 0; f < 9; f++) raw[(11-f)*32 +: 32] = pick_entry();
            for (int f = 9; f < 12; f++) raw[(11-f)*32 +: 32] = pick_spin();
            send_item(rmsv_pkg::req_type'(raw));
         end
      end
      req_valid <= 0;

      while (pending_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rmsv_pkg.sv
rtl/rmsv_sqrt.sv
rtl/rmsv_div.sv
rtl/rmsv_trig.sv
rtl/rmsv_rot.sv
rtl/rotate_matrix_by_spin_vector.sv
verif/rotation_checker.sv
verif/tb_top.sv
